// ===== src/mme_pkg.sv =====
`timescale 1ns / 1ps

package mme_pkg;

  localparam int IdxPortW = 3;
  localparam int DataW    = 32;
  localparam int DimW     = 4;
  localparam int AccW     = 64;
  localparam int CmdDepth = 4;
  localparam int ResDepth = 4;

  // request codes as they arrive on req_type_i
  typedef enum logic [1:0] {
    REQ_LOAD_A = 2'd0,
    REQ_LOAD_B = 2'd1,
    REQ_START  = 2'd2
  } req_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_ROWS_A    = 2'd0,
    CFG_INNER_DIM = 2'd1,
    CFG_COLS_B    = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  typedef struct packed {
    req_e                op;
    logic [IdxPortW-1:0] row;
    logic [IdxPortW-1:0] col;
    logic [DataW-1:0]    value;
  } cmd_t;

  typedef struct packed {
    logic [DataW-1:0]    value;
    logic [IdxPortW-1:0] row;
    logic [IdxPortW-1:0] col;
    logic                last;
  } res_t;

  typedef struct packed {
    logic [DimW-1:0] rows_a;
    logic [DimW-1:0] inner_dim;
    logic [DimW-1:0] cols_b;
  } dims_t;

endpackage

// ===== src/matrix_multiply_engine.sv =====
`timescale 1ns / 1ps
// Channel  | Handshake               | Payload
// ---------+-------------------------+----------------------------------------------
// request  | push / full             | req_type_i, row_i, col_i, elem_value_i
// result   | empty / pop             | result_value_o, out_row_o, out_col_o, last_result_o
// config   | cfg_we_i (no wait)      | cfg_idx_i, cfg_wdata_i
//
// Loads are taken at one per cycle while the command queue is not full and reach their
// store in order. A start steps through rows x inner x cols products in one MAC pipeline
// (read, multiply, accumulate, emit); a new element issues only while one of the four
// result slots is free, which limits issue when the inner dimension is one. A stalled
// result queue holds issue at the next element boundary; requests queue until the command
// queue fills and full rises. Reset clears control and the sizes (8 each).

module matrix_multiply_engine
  import mme_pkg::*;
#(
  parameter int MAX_DIM   = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          req_type_i,
  input  logic [IdxPortW-1:0] row_i,
  input  logic [IdxPortW-1:0] col_i,
  input  logic [DataW-1:0]    elem_value_i,
  output logic                empty,
  input  logic                pop,
  output logic [DataW-1:0]    result_value_o,
  output logic [IdxPortW-1:0] out_row_o,
  output logic [IdxPortW-1:0] out_col_o,
  output logic                last_result_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [DimW-1:0]     cfg_wdata_i
);

  dims_t dims_q;
  cmd_t  cmd;
  logic  cmd_empty, cmd_pop;
  res_t  res_in, res_out;
  logic  res_push, res_full;

  // Size registers keep the raw bits; clamping happens when a start is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q.rows_a    <= DimW'(8);
      dims_q.inner_dim <= DimW'(8);
      dims_q.cols_b    <= DimW'(8);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROWS_A:    dims_q.rows_a    <= cfg_wdata_i;
        CFG_INNER_DIM: dims_q.inner_dim <= cfg_wdata_i;
        CFG_COLS_B:    dims_q.cols_b    <= cfg_wdata_i;
        default:       dims_q           <= dims_q;
      endcase
    end
  end

  // Front: classify requests, drop unused codes and out-of-range loads, queue the rest in order.
  mme_front #(
    .MaxDim(MAX_DIM)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .req_type_i  (req_type_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .elem_value_i(elem_value_i),
    .cmd_o       (cmd),
    .cmd_empty_o (cmd_empty),
    .cmd_pop_i   (cmd_pop)
  );

  // Back: element stores and the multiply-accumulate pipeline.
  mme_back #(
    .MaxDim  (MAX_DIM),
    .FracBits(FRAC_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .dims_i     (dims_q),
    .cmd_i      (cmd),
    .cmd_empty_i(cmd_empty),
    .cmd_pop_o  (cmd_pop),
    .res_push_o (res_push),
    .res_o      (res_in),
    .res_pop_i  (pop && !empty)
  );

  // Result queue; the back side reserves a slot before each element starts.
  mme_fifo #(
    .Width($bits(res_t)),
    .Depth(ResDepth)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .din_i  (res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .dout_o (res_out),
    .empty_o(empty)
  );

  assign result_value_o = res_out.value;
  assign out_row_o      = res_out.row;
  assign out_col_o      = res_out.col;
  assign last_result_o  = res_out.last;

  // The slot reservation must never let a finished element meet a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_push |-> !res_full)
    else $error("result pushed into a full queue");

  // The back side takes commands only from a non-empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_pop |-> !cmd_empty)
    else $error("command popped from an empty queue");

  // A result pushed into an empty result queue shows on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (res_push && empty) |=> !empty)
    else $error("pushed result not visible");

endmodule

// ===== src/mme_fifo.sv =====
`timescale 1ns / 1ps

module mme_fifo #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] din_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] dout_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (PtrW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign dout_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (PtrW+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - (PtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= din_i;
    end
  end

endmodule

// ===== src/mme_front.sv =====
`timescale 1ns / 1ps

module mme_front
  import mme_pkg::*;
#(
  parameter int MaxDim = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  logic [1:0]          req_type_i,
  input  logic [IdxPortW-1:0] row_i,
  input  logic [IdxPortW-1:0] col_i,
  input  logic [DataW-1:0]    elem_value_i,
  output cmd_t                cmd_o,
  output logic                cmd_empty_o,
  input  logic                cmd_pop_i
);

  localparam logic [IdxPortW+1:0] DimLim = (IdxPortW+2)'(MaxDim);

  cmd_t cmd_in;
  logic in_range;
  logic keep;

  assign in_range = ({2'b00, row_i} < DimLim) && ({2'b00, col_i} < DimLim);

  // drop unused codes and loads that fall outside the store
  always_comb begin
    cmd_in.op    = REQ_START;
    cmd_in.row   = row_i;
    cmd_in.col   = col_i;
    cmd_in.value = elem_value_i;
    keep         = 1'b0;
    case (req_type_i)
      REQ_LOAD_A: begin
        cmd_in.op = REQ_LOAD_A;
        keep      = in_range;
      end
      REQ_LOAD_B: begin
        cmd_in.op = REQ_LOAD_B;
        keep      = in_range;
      end
      REQ_START: begin
        cmd_in.op = REQ_START;
        keep      = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  mme_fifo #(
    .Width($bits(cmd_t)),
    .Depth(CmdDepth)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i && keep),
    .din_i  (cmd_in),
    .full_o (full_o),
    .pop_i  (cmd_pop_i),
    .dout_o (cmd_o),
    .empty_o(cmd_empty_o)
  );

endmodule

// ===== src/mme_back.sv =====
`timescale 1ns / 1ps

module mme_back
  import mme_pkg::*;
#(
  parameter int MaxDim   = 8,
  parameter int FracBits = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  dims_t dims_i,
  input  cmd_t  cmd_i,
  input  logic  cmd_empty_i,
  output logic  cmd_pop_o,
  output logic  res_push_o,
  output res_t  res_o,
  input  logic  res_pop_i
);

  localparam int IdxW    = $clog2(MaxDim);
  localparam int DimCntW = IdxW + 1;
  localparam int AddrW   = 2 * IdxW;
  localparam int Depth   = 1 << AddrW;
  localparam int CredW   = $clog2(ResDepth + 1);

  localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};

  function automatic logic [DimCntW-1:0] clamp_dim(logic [DimW-1:0] v);
    if (v == '0) begin
      return DimCntW'(1);
    end else if ({1'b0, v} > (DimW+1)'(MaxDim)) begin
      return DimCntW'(MaxDim);
    end else begin
      return DimCntW'(v);
    end
  endfunction

  state_e state_q, state_d;

  logic [IdxW-1:0]    i_q, i_d, j_q, j_d, k_q, k_d;
  logic [DimCntW-1:0] m_q, m_d, n_q, n_d, p_q, p_d;
  logic [CredW-1:0]   credit_q, credit_d;

  logic issue, elem_start, k_end, j_end, i_end, all_end;
  logic start_cmd, we_a, we_b;
  logic [AddrW-1:0] waddr;

  logic [DataW-1:0] store_a_q [Depth];
  logic [DataW-1:0] store_b_q [Depth];

  // MAC pipeline: read, multiply, accumulate, emit
  logic                     s1_vld_q, s1_first_q, s1_fin_q, s1_last_q;
  logic [IdxW-1:0]          s1_row_q, s1_col_q;
  logic signed [DataW-1:0]  a_rd_q, b_rd_q;
  logic                     s2_vld_q, s2_first_q, s2_fin_q, s2_last_q;
  logic [IdxW-1:0]          s2_row_q, s2_col_q;
  logic signed [AccW-1:0]   prod_q;
  logic signed [AccW-1:0]   acc_q, acc_d, acc_base, prod_sh;
  logic signed [AccW:0]     sum_w;
  logic                     out_vld_q, out_last_q;
  logic [IdxW-1:0]          out_row_q, out_col_q;

  assign k_end   = ({1'b0, k_q} == n_q - DimCntW'(1));
  assign j_end   = ({1'b0, j_q} == p_q - DimCntW'(1));
  assign i_end   = ({1'b0, i_q} == m_q - DimCntW'(1));
  assign all_end = k_end && j_end && i_end;

  // a new result element starts only with a free slot in the result queue
  assign issue      = (state_q == ST_RUN) && ((k_q != '0) || (credit_q != '0));
  assign elem_start = issue && (k_q == '0);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (!cmd_empty_i && (cmd_i.op == REQ_START)) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (issue && all_end) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_pop_o = 1'b0;
    case (state_q)
      ST_IDLE: cmd_pop_o = !cmd_empty_i;
      ST_RUN:  cmd_pop_o = 1'b0;
      default: cmd_pop_o = 1'b0;
    endcase
  end

  assign start_cmd = cmd_pop_o && (cmd_i.op == REQ_START);
  assign we_a      = cmd_pop_o && (cmd_i.op == REQ_LOAD_A);
  assign we_b      = cmd_pop_o && (cmd_i.op == REQ_LOAD_B);
  assign waddr     = {IdxW'(cmd_i.row), IdxW'(cmd_i.col)};

  always_comb begin
    i_d = i_q;
    j_d = j_q;
    k_d = k_q;
    m_d = m_q;
    n_d = n_q;
    p_d = p_q;
    if (start_cmd) begin
      i_d = '0;
      j_d = '0;
      k_d = '0;
      m_d = clamp_dim(dims_i.rows_a);
      n_d = clamp_dim(dims_i.inner_dim);
      p_d = clamp_dim(dims_i.cols_b);
    end else if (issue) begin
      if (!k_end) begin
        k_d = k_q + IdxW'(1);
      end else begin
        k_d = '0;
        if (!j_end) begin
          j_d = j_q + IdxW'(1);
        end else begin
          j_d = '0;
          i_d = i_q + IdxW'(1);
        end
      end
    end
  end

  always_comb begin
    credit_d = credit_q;
    if (elem_start && !res_pop_i) begin
      credit_d = credit_q - CredW'(1);
    end else if (res_pop_i && !elem_start) begin
      credit_d = credit_q + CredW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      i_q      <= '0;
      j_q      <= '0;
      k_q      <= '0;
      m_q      <= DimCntW'(1);
      n_q      <= DimCntW'(1);
      p_q      <= DimCntW'(1);
      credit_q <= CredW'(ResDepth);
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      i_q      <= i_d;
      j_q      <= j_d;
      k_q      <= k_d;
      m_q      <= m_d;
      n_q      <= n_d;
      p_q      <= p_d;
      credit_q <= credit_d;
      s1_vld_q <= issue;
      s2_vld_q <= s1_vld_q;
      out_vld_q <= s2_vld_q && s2_fin_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_a) begin
      store_a_q[waddr] <= cmd_i.value;
    end
    if (we_b) begin
      store_b_q[waddr] <= cmd_i.value;
    end
    if (issue) begin
      a_rd_q <= store_a_q[{i_q, k_q}];
      b_rd_q <= store_b_q[{k_q, j_q}];
    end
  end

  always_ff @(posedge clk_i) begin
    s1_first_q <= (k_q == '0);
    s1_fin_q   <= k_end;
    s1_last_q  <= all_end;
    s1_row_q   <= i_q;
    s1_col_q   <= j_q;
    s2_first_q <= s1_first_q;
    s2_fin_q   <= s1_fin_q;
    s2_last_q  <= s1_last_q;
    s2_row_q   <= s1_row_q;
    s2_col_q   <= s1_col_q;
    prod_q     <= a_rd_q * b_rd_q;
    if (s2_vld_q) begin
      acc_q <= acc_d;
    end
    if (s2_vld_q && s2_fin_q) begin
      out_row_q  <= s2_row_q;
      out_col_q  <= s2_col_q;
      out_last_q <= s2_last_q;
    end
  end

  // floor the product to the fixed-point grid, add with saturation
  always_comb begin
    acc_base = s2_first_q ? '0 : acc_q;
    prod_sh  = prod_q >>> FracBits;
    sum_w    = {acc_base[AccW-1], acc_base} + {prod_sh[AccW-1], prod_sh};
    if (sum_w[AccW] != sum_w[AccW-1]) begin
      acc_d = sum_w[AccW] ? AccMin : AccMax;
    end else begin
      acc_d = sum_w[AccW-1:0];
    end
  end

  always_comb begin
    res_o.row  = IdxPortW'(out_row_q);
    res_o.col  = IdxPortW'(out_col_q);
    res_o.last = out_last_q;
    if (acc_q[AccW-1:DataW-1] == '0 || acc_q[AccW-1:DataW-1] == '1) begin
      res_o.value = acc_q[DataW-1:0];
    end else if (acc_q[AccW-1]) begin
      res_o.value = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      res_o.value = {1'b0, {(DataW-1){1'b1}}};
    end
  end

  assign res_push_o = out_vld_q;

endmodule
